// File: src/fsr_pkg.sv
// ----------------------------------------------------------------------------
// fsr_pkg: shared types and constants of the float32 sqrt / rsqrt pipeline
// Stage payload structs, step counts and IEEE-754 single constants.
// ----------------------------------------------------------------------------
package fsr_pkg;

  // Digit-by-digit root of m * 4^42 gives a 55-bit root, one bit per stage.
  localparam int SQ_STEPS   = 55;
  // Operand pairs come from m only for the top 13 root bits.
  localparam int SQ_M_FLOOR = 42;
  // Restoring reciprocal division, one quotient bit per stage.
  localparam int DV_STEPS   = 56;

  localparam logic [31:0] QNAN_DEFAULT = 32'h7FC0_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
  localparam logic [31:0] POS_INF      = 32'h7F80_0000;
  localparam logic [31:0] POS_ZERO     = 32'h0000_0000;

  typedef struct packed {
    logic               row_end;
    logic               inv;
    logic               done;
    logic [31:0]        res;
    logic signed [9:0]  half;
    logic [25:0]        m;
    logic [59:0]        rem;
    logic [54:0]        root;
  } sq_t;

  typedef struct packed {
    logic               row_end;
    logic               done;
    logic [31:0]        res;
    logic signed [9:0]  es;
    logic [52:0]        d;
    logic [53:0]        rem;
    logic [55:0]        quo;
  } dv_t;

  typedef struct packed {
    logic               row_end;
    logic               done;
    logic [31:0]        res;
    logic signed [9:0]  er;
    logic [52:0]        r53;
  } f1_t;

endpackage

// File: src/fsr_in_if.sv
// ----------------------------------------------------------------------------
// fsr_in_if: operand channel
// Valid/ready channel carrying one binary32 operand and its row-end flag.
// ----------------------------------------------------------------------------
interface fsr_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] operand_bits;
  logic        row_end;

  modport source (output valid, output operand_bits, output row_end, input ready);
  modport sink   (input valid, input operand_bits, input row_end, output ready);
endinterface

// File: src/fsr_out_if.sv
// ----------------------------------------------------------------------------
// fsr_out_if: result channel
// Valid/ready channel carrying one binary32 result and the row-end copy.
// ----------------------------------------------------------------------------
interface fsr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_bits;
  logic        row_end_out;

  modport source (output valid, output result_bits, output row_end_out, input ready);
  modport sink   (input valid, input result_bits, input row_end_out, output ready);
endinterface

// File: src/float32_sqrt_or_rsqrt.sv
// ----------------------------------------------------------------------------
// float32_sqrt_or_rsqrt: pipelined binary32 square root / reciprocal root
// Decode, 55 root stages, root rounding, 56 division stages, two rounding
// stages. Square root is rounded once; rsqrt goes through double precision.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; the bit-serial root and divide stages set
// the depth, and the whole pipeline holds when the output beat is not taken.
// Reset (rst_n low, synchronous) clears all valid bits and sets square-root
// mode; payload registers are not reset.
module float32_sqrt_or_rsqrt (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  fsr_in_if.sink       in_if,
  fsr_out_if.source    out_if
);

  localparam int SQN = fsr_pkg::SQ_STEPS;
  localparam int DVN = fsr_pkg::DV_STEPS;

  logic mode_r;
  logic adv;

  fsr_pkg::sq_t sq_r   [0:SQN];
  fsr_pkg::sq_t sq_nxt [0:SQN];
  logic [SQN:0] sq_v_r;

  fsr_pkg::dv_t dv_r   [0:DVN];
  fsr_pkg::dv_t dv_nxt [0:DVN];
  logic [DVN:0] dv_v_r;

  fsr_pkg::f1_t f1_r, f1_nxt;
  logic         f1_v_r;
  logic [31:0]  f2_res_r, f2_res_nxt;
  logic         f2_row_r;
  logic         f2_v_r;

  // The whole pipeline moves together; it holds only when the output is stuck.
  assign adv         = !f2_v_r || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // ---------------- decode and normalize ----------------
  logic              dec_sgn;
  logic [7:0]        dec_e;
  logic [22:0]       dec_f;
  logic [4:0]        dec_msb;
  logic [23:0]       dec_mn;
  logic signed [9:0] dec_q;
  logic signed [9:0] dec_qe;

  always_comb begin
    dec_sgn = in_if.operand_bits[31];
    dec_e   = in_if.operand_bits[30:23];
    dec_f   = in_if.operand_bits[22:0];
    dec_msb = 5'd0;
    for (int k = 0; k < 23; k++) begin
      if (dec_f[k]) begin
        dec_msb = 5'(k);
      end
    end
    if (dec_e == 8'd0) begin
      dec_mn = 24'({1'b0, dec_f} << (5'd23 - dec_msb));
      dec_q  = $signed({5'b0, dec_msb}) - 10'sd172;
    end else begin
      dec_mn = {1'b1, dec_f};
      dec_q  = $signed({2'b0, dec_e}) - 10'sd150;
    end
    dec_qe = dec_q[0] ? (dec_q - 10'sd1) : dec_q;

    sq_nxt[0]         = '0;
    sq_nxt[0].row_end = in_if.row_end;
    sq_nxt[0].inv     = mode_r;
    sq_nxt[0].m       = dec_q[0] ? {1'b0, dec_mn, 1'b0} : {2'b0, dec_mn};
    sq_nxt[0].half    = dec_qe >>> 1;
    if (dec_e == 8'hFF && dec_f != 23'd0) begin
      sq_nxt[0].done = 1'b1;
      sq_nxt[0].res  = in_if.operand_bits | fsr_pkg::QUIET_BIT;
    end else if (dec_e == 8'd0 && dec_f == 23'd0) begin
      sq_nxt[0].done = 1'b1;
      sq_nxt[0].res  = mode_r ? ({dec_sgn, 31'd0} | fsr_pkg::POS_INF)
                              : in_if.operand_bits;
    end else if (dec_sgn) begin
      sq_nxt[0].done = 1'b1;
      sq_nxt[0].res  = fsr_pkg::QNAN_DEFAULT;
    end else if (dec_e == 8'hFF) begin
      sq_nxt[0].done = 1'b1;
      sq_nxt[0].res  = mode_r ? fsr_pkg::POS_ZERO : fsr_pkg::POS_INF;
    end
  end

  // ---------------- square root, one root bit per stage ----------------
  for (genvar j = 0; j < SQN; j++) begin : g_sq
    localparam int I = SQN - 1 - j;
    logic [1:0]  two;
    logic [59:0] rem_s;
    logic [59:0] trial;

    if (I >= fsr_pkg::SQ_M_FLOOR) begin : g_pair
      assign two = sq_r[j].m[2*(I-fsr_pkg::SQ_M_FLOOR)+1 -: 2];
    end else begin : g_zero
      assign two = 2'b00;
    end

    always_comb begin
      rem_s       = {sq_r[j].rem[57:0], two};
      trial       = {3'b0, sq_r[j].root, 2'b01};
      sq_nxt[j+1] = sq_r[j];
      if (rem_s >= trial) begin
        sq_nxt[j+1].rem  = rem_s - trial;
        sq_nxt[j+1].root = {sq_r[j].root[53:0], 1'b1};
      end else begin
        sq_nxt[j+1].rem  = rem_s;
        sq_nxt[j+1].root = {sq_r[j].root[53:0], 1'b0};
      end
    end
  end

  // ---------------- round the root ----------------
  logic [54:0]       rr_root;
  logic              rr_b54;
  logic              rr_st;
  logic [23:0]       rr_k24;
  logic              rr_h24;
  logic              rr_s24;
  logic signed [9:0] rr_ex;
  logic [52:0]       rr_k53;
  logic              rr_h53;
  logic              rr_s53;
  logic [53:0]       rr_sum;
  logic signed [9:0] rr_es;

  always_comb begin
    rr_root = sq_r[SQN].root;
    rr_b54  = rr_root[54];
    rr_st   = (sq_r[SQN].rem != 60'd0);
    rr_k24  = rr_b54 ? rr_root[54:31] : rr_root[53:30];
    rr_h24  = rr_b54 ? rr_root[30] : rr_root[29];
    rr_s24  = rr_st | (rr_b54 ? (rr_root[29:0] != 30'd0) : (rr_root[28:0] != 29'd0));
    rr_ex   = sq_r[SQN].half + (rr_b54 ? 10'sd139 : 10'sd138);
    rr_k53  = rr_b54 ? rr_root[54:2] : rr_root[53:1];
    rr_h53  = rr_b54 ? rr_root[1] : rr_root[0];
    rr_s53  = rr_st | (rr_b54 & rr_root[0]);
    rr_sum  = {1'b0, rr_k53} + 54'(rr_h53 & (rr_s53 | rr_k53[0]));
    rr_es   = sq_r[SQN].half + (rr_b54 ? -10'sd40 : -10'sd41);

    dv_nxt[0]         = '0;
    dv_nxt[0].row_end = sq_r[SQN].row_end;
    dv_nxt[0].done    = sq_r[SQN].done || !sq_r[SQN].inv;
    dv_nxt[0].rem     = 54'(1) << 51;
    if (sq_r[SQN].done) begin
      dv_nxt[0].res = sq_r[SQN].res;
    end else begin
      // Rounding carry out of the fraction bumps the exponent field.
      dv_nxt[0].res = {1'b0, rr_ex[7:0], rr_k24[22:0]}
                      + 32'(rr_h24 & (rr_s24 | rr_k24[0]));
    end
    if (rr_sum[53]) begin
      dv_nxt[0].d  = rr_sum[53:1];
      dv_nxt[0].es = rr_es + 10'sd1;
    end else begin
      dv_nxt[0].d  = rr_sum[52:0];
      dv_nxt[0].es = rr_es;
    end
  end

  // ---------------- reciprocal division, one quotient bit per stage --------
  for (genvar j = 0; j < DVN; j++) begin : g_dv
    logic [53:0] rem_s;

    always_comb begin
      rem_s       = {dv_r[j].rem[52:0], 1'b0};
      dv_nxt[j+1] = dv_r[j];
      if (rem_s >= {1'b0, dv_r[j].d}) begin
        dv_nxt[j+1].rem = rem_s - {1'b0, dv_r[j].d};
        dv_nxt[j+1].quo = {dv_r[j].quo[54:0], 1'b1};
      end else begin
        dv_nxt[j+1].rem = rem_s;
        dv_nxt[j+1].quo = {dv_r[j].quo[54:0], 1'b0};
      end
    end
  end

  // ---------------- round quotient to 53 bits ----------------
  logic [55:0]       q1_quo;
  logic signed [9:0] q1_er;
  logic [52:0]       q1_k;
  logic [53:0]       q1_sum;

  always_comb begin
    q1_quo = dv_r[DVN].quo;
    q1_er  = -dv_r[DVN].es - 10'sd107;
    q1_k   = q1_quo[54:2];
    q1_sum = {1'b0, q1_k}
             + 54'(q1_quo[1] & (q1_quo[0] | (dv_r[DVN].rem != 54'd0) | q1_k[0]));
    f1_nxt         = '0;
    f1_nxt.row_end = dv_r[DVN].row_end;
    f1_nxt.done    = dv_r[DVN].done;
    f1_nxt.res     = dv_r[DVN].res;
    if (q1_quo[55]) begin
      // Exact power of two, divisor was the smallest significand.
      f1_nxt.r53 = q1_quo[55:3];
      f1_nxt.er  = q1_er + 10'sd3;
    end else if (q1_sum[53]) begin
      f1_nxt.r53 = q1_sum[53:1];
      f1_nxt.er  = q1_er + 10'sd3;
    end else begin
      f1_nxt.r53 = q1_sum[52:0];
      f1_nxt.er  = q1_er + 10'sd2;
    end
  end

  // ---------------- round to 24 bits and pack ----------------
  logic signed [9:0] q2_fld;

  always_comb begin
    q2_fld = f1_r.er + 10'sd179;
    if (f1_r.done) begin
      f2_res_nxt = f1_r.res;
    end else begin
      f2_res_nxt = {1'b0, q2_fld[7:0], f1_r.r53[51:29]}
                   + 32'(f1_r.r53[28] & ((f1_r.r53[27:0] != 28'd0) | f1_r.r53[29]));
    end
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= '0;
      dv_v_r <= '0;
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
    end else if (adv) begin
      sq_v_r <= {sq_v_r[SQN-1:0], in_if.valid};
      dv_v_r <= {dv_v_r[DVN-1:0], sq_v_r[SQN]};
      f1_v_r <= dv_v_r[DVN];
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k <= SQN; k++) begin
        sq_r[k] <= sq_nxt[k];
      end
      for (int k = 0; k <= DVN; k++) begin
        dv_r[k] <= dv_nxt[k];
      end
      f1_r     <= f1_nxt;
      f2_res_r <= f2_res_nxt;
      f2_row_r <= f1_r.row_end;
    end
  end

  assign out_if.valid       = f2_v_r;
  assign out_if.result_bits = f2_res_r;
  assign out_if.row_end_out = f2_row_r;

  // ---------------- assertions ----------------
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> sq_v_r[0])
    else $error("accepted beat did not enter the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(sq_v_r) && $stable(dv_v_r) && $stable(f1_v_r))
    else $error("pipeline moved while output was stalled");

  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.result_bits[30:23] == 8'hFF && out_if.result_bits[22:0] != 23'd0
    |-> out_if.result_bits[22])
    else $error("signaling NaN on the output");

endmodule

// File: bench/float32_sqrt_or_rsqrt_checker.sv
// ----------------------------------------------------------------------------
// float32_sqrt_or_rsqrt_checker: result predictor and scoreboard
// Watches the operand, result and mode ports, predicts each result bit for
// bit with integer arithmetic and compares every result beat in order.
// ----------------------------------------------------------------------------
module float32_sqrt_or_rsqrt_checker (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  fsr_in_if    in_if,
  fsr_out_if   out_if,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] result_bits;
    logic        row_end_out;
  } root_result_t;

  root_result_t expected_roots[$];
  logic         inverse_mode;

  function automatic int bit_len(logic [127:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) n = i + 1;
    end
    return n;
  endfunction

  // Round to p significant bits, nearest even; ex tracks the binary scale.
  function automatic logic [127:0] round_sig(logic [127:0] v, bit sticky, int p,
                                             inout int ex);
    int          sh;
    logic [127:0] keep, low;
    bit          half_bit;
    sh = bit_len(v) - p;
    if (sh <= 0) begin
      ex = ex + sh;
      return v << (-sh);
    end
    keep     = v >> sh;
    half_bit = v[sh-1];
    low      = v & ((128'd1 << (sh - 1)) - 1);
    ex       = ex + sh;
    if (half_bit && (low != 0 || sticky || keep[0])) keep = keep + 1;
    if ((keep >> p) != 0) begin
      keep = keep >> 1;
      ex   = ex + 1;
    end
    return keep;
  endfunction

  function automatic logic [63:0] floor_root(logic [127:0] n, output bit inexact);
    logic [127:0] rem, trial;
    logic [63:0]  root;
    rem  = 0;
    root = 0;
    for (int i = 63; i >= 0; i--) begin
      rem   = (rem << 2) | ((n >> (2 * i)) & 128'd3);
      trial = ({64'd0, root} << 2) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    inexact = (rem != 0);
    return root;
  endfunction

  function automatic logic [31:0] predict_root(logic [31:0] x, logic inv);
    logic [7:0]   e;
    logic [22:0]  f;
    logic [127:0] m, root, s53, quo, r53, sig;
    int           q, half_exp, ex;
    bit           st, st2;
    e = x[30:23];
    f = x[22:0];
    if (e == 8'hFF && f != 0) return x | fsr_pkg::QUIET_BIT;
    if (e == 0 && f == 0) return inv ? ({x[31], 31'd0} | fsr_pkg::POS_INF) : x;
    if (x[31]) return fsr_pkg::QNAN_DEFAULT;
    if (e == 8'hFF) return inv ? fsr_pkg::POS_ZERO : fsr_pkg::POS_INF;
    if (e == 0) begin
      m = {105'd0, f};
      q = -149;
      while (m[23] == 0) begin
        m = m << 1;
        q = q - 1;
      end
    end else begin
      m = {104'd0, 1'b1, f};
      q = int'(e) - 150;
    end
    if ((q % 2) != 0) begin
      m = m << 1;
      q = q - 1;
    end
    half_exp = q / 2;
    if (!inv) begin
      root = {64'd0, floor_root(m << 26, st)};
      ex   = half_exp - 13;
      sig  = round_sig(root, st, 24, ex);
    end else begin
      root = {64'd0, floor_root(m << 84, st)};
      ex   = half_exp - 42;
      s53  = round_sig(root, st, 53, ex);
      quo  = (128'd1 << 107) / s53;
      st2  = ((128'd1 << 107) % s53) != 0;
      ex   = -ex - 107;
      r53  = round_sig(quo, st2, 53, ex);
      sig  = round_sig(r53, 1'b0, 24, ex);
    end
    return {1'b0, 8'(ex + 150), sig[22:0]};
  endfunction

  always @(posedge clk) begin
    root_result_t want;
    if (!rst_n) begin
      inverse_mode <= 1'b0;
      fail_count   <= 0;
    end else begin
      if (cfg_we) inverse_mode <= cfg_wdata;
      if (in_if.valid && in_if.ready) begin
        want.result_bits = predict_root(in_if.operand_bits, inverse_mode);
        want.row_end_out = in_if.row_end;
        expected_roots.push_back(want);
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_roots.size() == 0) begin
          $error("result beat with nothing expected: result_bits %h", out_if.result_bits);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_roots.pop_front();
          if (out_if.result_bits !== want.result_bits) begin
            $error("result_bits: expected %h actual %h", want.result_bits,
                   out_if.result_bits);
            fail_count <= fail_count + 1;
          end
          if (out_if.row_end_out !== want.row_end_out) begin
            $error("row_end_out: expected %b actual %b", want.row_end_out,
                   out_if.row_end_out);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_roots.size();
  end
endmodule

// File: bench/float32_sqrt_or_rsqrt_test.sv
// ----------------------------------------------------------------------------
// float32_sqrt_or_rsqrt_test: top of the sqrt / rsqrt regression
// Drives directed and random operands in both modes with random idling on
// both channels and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module float32_sqrt_or_rsqrt_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 115;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  int   fail_count;
  int   pending;
  int   in_idle_pct = 34;
  int   out_idle_pct = 34;

  fsr_in_if  in_if();
  fsr_out_if out_if();

  float32_sqrt_or_rsqrt i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_if),
    .out_if   (out_if)
  );

  float32_sqrt_or_rsqrt_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_if     (in_if),
    .out_if    (out_if),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always #2 clk = ~clk;

  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  task automatic send_operand(logic [31:0] operand, logic row_end);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid        = 1'b1;
    in_if.operand_bits = operand;
    in_if.row_end      = row_end;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // The block must be empty before the mode changes.
  task automatic drain_and_set_mode(logic mode);
    in_if.valid = 1'b0;
    wait (pending == 0);
    repeat (LATENCY + 10) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = mode;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(9))
      0, 1, 2: v[31] = 1'b0;
      3:       v[30:23] = 8'h00;
      4:       v[30:23] = 8'hFF;
      5:       v = {v[31], 31'd0};
      6:       v = {1'b0, 8'($urandom_range(254, 1)), 23'($urandom_range(3))};
      default: ;
    endcase
    return v;
  endfunction

  logic [31:0] directed_ops[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7F80_0001, 32'hFFFF_FFFF, 32'h7FC0_0000, 32'h0000_0001,
    32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000,
    32'h4080_0000, 32'hBF80_0000, 32'h4000_0000, 32'h3F7F_FFFF,
    32'h0040_0000, 32'hFFBF_FFFF
  };

  initial begin
    in_if.valid        = 1'b0;
    in_if.operand_bits = '0;
    in_if.row_end      = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int phase = 0; phase < 6; phase++) begin
      drain_and_set_mode(phase[0]);
      if (phase < 2) begin
        foreach (directed_ops[i]) send_operand(directed_ops[i], i[0]);
      end else begin
        in_idle_pct  = (phase == 3) ? 0 : 34;
        out_idle_pct = (phase == 3) ? 0 : 34;
        for (int n = 0; n < 150; n++) begin
          if (n == 75) begin
            in_if.valid = 1'b0;
            wait (pending == 0);
            @(negedge clk);
          end
          send_operand(random_operand(), 1'($urandom_range(1)));
        end
      end
    end
    in_if.valid = 1'b0;
    out_idle_pct = 34;
    wait (pending == 0);
    repeat (LATENCY + 20) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
